@@ design/tpg_pkg.sv @@
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types and constants of the TCP port gate: frame offsets, protocol
// codes, parse status codes, register indexes and the item/result records.
// ----------------------------------------------------------------------------
package tpg_pkg;

  // sizing
  localparam int PREFIX_LEN   = 511;
  localparam int OFFSET_WIDTH = 16;
  localparam int CNT_W        = $clog2(PREFIX_LEN + 1);
  localparam int L4_W         = 7;   // 14 + 15*4 + 19 fits
  localparam int DS_W         = 8;   // 14 + 15*4 + 15*4 fits

  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};
  localparam logic [CNT_W-1:0]        PREFIX_MAX = CNT_W'(PREFIX_LEN);

  // frame layout and protocol codes
  localparam logic [OFFSET_WIDTH-1:0] OFS_ETYPE_HI = OFFSET_WIDTH'(12);
  localparam logic [OFFSET_WIDTH-1:0] OFS_ETYPE_LO = OFFSET_WIDTH'(13);
  localparam logic [OFFSET_WIDTH-1:0] OFS_IP_IHL   = OFFSET_WIDTH'(14);
  localparam logic [OFFSET_WIDTH-1:0] OFS_IP_PROTO = OFFSET_WIDTH'(23);
  localparam logic [L4_W-1:0]         ETH_HDR_LEN  = L4_W'(14);
  localparam logic [L4_W-1:0]         TCP_DPORT_HI = L4_W'(2);
  localparam logic [L4_W-1:0]         TCP_DPORT_LO = L4_W'(3);
  localparam logic [L4_W-1:0]         TCP_DOFF     = L4_W'(12);
  localparam logic [L4_W-1:0]         TCP_HDR_LAST = L4_W'(19);
  localparam logic [15:0]             ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]              IP_PROTO_TCP = 8'd6;
  localparam logic [3:0]              MIN_HDR_WORDS = 4'd5;

  // parse status codes
  localparam logic [2:0] ST_UNDECIDED  = 3'd0;
  localparam logic [2:0] ST_PASS       = 3'd1;
  localparam logic [2:0] ST_PORT_MATCH = 3'd2;
  localparam logic [2:0] ST_MATCH      = 3'd3;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_ALLOW   = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       prefix_full;
    logic       verdict_valid;
    logic       drop;
    logic       event_sent;
  } result_t;

endpackage

@@ design/tpg_in_if.sv @@
// ----------------------------------------------------------------------------
// tpg_in_if
// Frame byte channel: valid/ready handshake with one byte and an end flag.
// ----------------------------------------------------------------------------
interface tpg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ design/tpg_out_if.sv @@
// ----------------------------------------------------------------------------
// tpg_out_if
// Result channel: captured payload byte and/or end-of-frame verdict.
// ----------------------------------------------------------------------------
interface tpg_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       prefix_full;
  logic       verdict_valid;
  logic       drop;
  logic       event_sent;

  modport source (
    output valid, output payload_valid, output payload_byte, output prefix_full,
    output verdict_valid, output drop, output event_sent, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input prefix_full,
    input verdict_valid, input drop, input event_sent, output ready
  );
endinterface

@@ design/tcp_port_gate_with_payload_capture.sv @@
// ----------------------------------------------------------------------------
// tcp_port_gate_with_payload_capture
// Ethernet/IPv4/TCP destination port gate with payload prefix capture.
//
//   channel   dir   signals                                   moves
//   in_chan   in    frame_byte, frame_end                     one frame byte
//   out_chan  out   payload_*, prefix_full, verdict_*, drop,  one result
//                   event_sent
//   cfg_*     in    cfg_we, cfg_index, cfg_data               one register
//
// One byte per cycle, unless a byte with a result waits on a stalled output.
// A byte is held in the input register and parsed there; its result (if any)
// lands in the output register when the byte is consumed. Reset is synchronous,
// active low, and clears the valid flags, config registers and frame state.
// A stalled output holds only bytes that produce a result; others keep flowing.
// ----------------------------------------------------------------------------
module tcp_port_gate_with_payload_capture (
  input  logic                                clk,
  input  logic                                rst_n,
  tpg_in_if.sink                              in_chan,
  tpg_out_if.source                           out_chan,
  input  logic                                cfg_we,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tpg_pkg::*;

  logic [15:0] target_port_r;
  logic        job_allow_r;

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  result_t     out_res_r;

  logic        has_result;
  result_t     result;
  logic        out_free;
  logic        s1_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_port_r <= '0;
      job_allow_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_PORT: target_port_r <= cfg_data[15:0];
        CFG_JOB_ALLOW:   job_allow_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && (!has_result || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_item_r.frame_byte <= in_chan.frame_byte;
      s1_item_r.frame_end  <= in_chan.frame_end;
    end
  end

  tpg_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (s1_item_r),
    .item_fire   (s1_fire),
    .target_port (target_port_r),
    .job_allow   (job_allow_r),
    .has_result  (has_result),
    .result      (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_res_r <= result;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.payload_valid = out_res_r.payload_valid;
  assign out_chan.payload_byte  = out_res_r.payload_byte;
  assign out_chan.prefix_full   = out_res_r.prefix_full;
  assign out_chan.verdict_valid = out_res_r.verdict_valid;
  assign out_chan.drop          = out_res_r.drop;
  assign out_chan.event_sent    = out_res_r.event_sent;

endmodule

@@ design/tpg_parser.sv @@
// ----------------------------------------------------------------------------
// tpg_parser
// Per-frame header tracker: byte offset, header fields, parse status and
// capture count. Works out the result of the presented byte in one pass and
// commits the frame state when the byte is consumed.
// ----------------------------------------------------------------------------
module tpg_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  tpg_pkg::item_t  item,
  input  logic            item_fire,
  input  logic [15:0]     target_port,
  input  logic            job_allow,
  output logic            has_result,
  output tpg_pkg::result_t result
);
  import tpg_pkg::*;

  logic [OFFSET_WIDTH-1:0] offset_r, offset_nxt;
  logic [7:0]              etype_hi_r, etype_hi_nxt;
  logic [L4_W-1:0]         l4_r, l4_nxt;
  logic [7:0]              dport_hi_r, dport_hi_nxt;
  logic [DS_W-1:0]         data_start_r, data_start_nxt;
  logic                    doff_ok_r, doff_ok_nxt;
  logic [2:0]              status_r, status_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic [7:0]              b;
  logic                    cap;
  logic                    full;

  // header decode for the presented byte
  always_comb begin
    b              = item.frame_byte;
    offset_nxt     = (offset_r < OFFSET_MAX) ? offset_r + 1'b1 : offset_r;
    etype_hi_nxt   = etype_hi_r;
    l4_nxt         = l4_r;
    dport_hi_nxt   = dport_hi_r;
    data_start_nxt = data_start_r;
    doff_ok_nxt    = doff_ok_r;
    status_nxt     = status_r;
    cnt_nxt        = cnt_r;
    cap            = 1'b0;
    full           = 1'b0;

    // ethernet and ip header checks
    if (offset_r == OFS_ETYPE_HI) begin
      etype_hi_nxt = b;
    end else if (offset_r == OFS_ETYPE_LO) begin
      if (status_r == ST_UNDECIDED && {etype_hi_r, b} != ETYPE_IPV4) status_nxt = ST_PASS;
    end else if (offset_r == OFS_IP_IHL) begin
      l4_nxt = ETH_HDR_LEN + {1'b0, b[3:0], 2'b00};
      if (status_r == ST_UNDECIDED && b[3:0] < MIN_HDR_WORDS) status_nxt = ST_PASS;
    end else if (offset_r == OFS_IP_PROTO) begin
      if (status_r == ST_UNDECIDED && b != IP_PROTO_TCP) status_nxt = ST_PASS;
    end

    // tcp header and payload
    if (offset_r > OFS_IP_IHL && status_nxt != ST_PASS) begin
      if (offset_r == OFFSET_WIDTH'(l4_r + TCP_DPORT_HI)) begin
        dport_hi_nxt = b;
      end else if (offset_r == OFFSET_WIDTH'(l4_r + TCP_DPORT_LO)) begin
        if (target_port == 16'd0 || {dport_hi_r, b} != target_port) status_nxt = ST_PASS;
        else status_nxt = ST_PORT_MATCH;
      end else if (offset_r == OFFSET_WIDTH'(l4_r + TCP_DOFF)) begin
        data_start_nxt = DS_W'(l4_r) + DS_W'({b[7:4], 2'b00});
        doff_ok_nxt    = b[7:4] >= MIN_HDR_WORDS;
      end
      if (offset_r == OFFSET_WIDTH'(l4_r + TCP_HDR_LAST) && status_nxt == ST_PORT_MATCH) begin
        status_nxt = ST_MATCH;
      end
      if (status_nxt == ST_MATCH && job_allow && doff_ok_r &&
          offset_r >= OFFSET_WIDTH'(data_start_r) && cnt_r < PREFIX_MAX) begin
        cap     = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        full    = cnt_nxt == PREFIX_MAX;
      end
    end
  end

  // result of this byte
  always_comb begin
    has_result           = cap || item.frame_end;
    result.payload_valid = cap;
    result.payload_byte  = cap ? b : 8'd0;
    result.prefix_full   = full;
    result.verdict_valid = item.frame_end;
    result.drop          = item.frame_end && status_nxt == ST_MATCH && !job_allow;
    result.event_sent    = item.frame_end && cnt_nxt != '0;
  end

  // frame state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      etype_hi_r   <= '0;
      l4_r         <= ETH_HDR_LEN;
      dport_hi_r   <= '0;
      data_start_r <= '0;
      doff_ok_r    <= 1'b0;
      status_r     <= ST_UNDECIDED;
      cnt_r        <= '0;
    end else if (item_fire) begin
      if (item.frame_end) begin
        offset_r     <= '0;
        etype_hi_r   <= '0;
        l4_r         <= ETH_HDR_LEN;
        dport_hi_r   <= '0;
        data_start_r <= '0;
        doff_ok_r    <= 1'b0;
        status_r     <= ST_UNDECIDED;
        cnt_r        <= '0;
      end else begin
        offset_r     <= offset_nxt;
        etype_hi_r   <= etype_hi_nxt;
        l4_r         <= l4_nxt;
        dport_hi_r   <= dport_hi_nxt;
        data_start_r <= data_start_nxt;
        doff_ok_r    <= doff_ok_nxt;
        status_r     <= status_nxt;
        cnt_r        <= cnt_nxt;
      end
    end
  end

endmodule
